// ----- rtl/ttfw_pkg.sv -----
// Package for the text terminal framebuffer writer: sizes, command codes,
// config register indexes and sequencer states. No dependencies.
package ttfw_pkg;

    localparam int TEXT_COLUMNS = 80;
    localparam int TEXT_ROWS    = 30;
    localparam int GLYPH_COUNT  = 256;

    localparam int LINE_BYTES   = 40;
    localparam int ROW_BYTES    = 320;
    localparam int FRAME_BYTES  = TEXT_ROWS * ROW_BYTES;
    localparam int GLYPH_WORDS  = GLYPH_COUNT * 2;
    localparam int BLINK_PERIOD = 30;

    localparam int FA_W = $clog2(FRAME_BYTES);
    localparam int GA_W = (GLYPH_WORDS > 1) ? $clog2(GLYPH_WORDS) : 1;

    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    typedef enum logic [2:0] {
        K_CHAR   = 3'd0,
        K_SETCUR = 3'd1,
        K_VSYNC  = 3'd2,
        K_CLS    = 3'd3,
        K_CLL    = 3'd4,
        K_RESET  = 3'd5,
        K_READ   = 3'd6,
        K_GLYPH  = 3'd7
    } t_kind;

    localparam logic [1:0] REG_FIRST = 2'd0;
    localparam logic [1:0] REG_LAST  = 2'd1;
    localparam logic [1:0] REG_FORE  = 2'd2;
    localparam logic [1:0] REG_BACK  = 2'd3;

    // Cell operations on the eight lines under the cursor.
    typedef enum logic [1:0] {
        CO_ERASE,
        CO_INVERT,
        CO_DRAW
    } t_cellop;

    // What happens after the cell pass.
    typedef enum logic [2:0] {
        AF_NONE,
        AF_LF,
        AF_DOWN,
        AF_ADV,
        AF_SETCUR
    } t_after;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GLY0,
        S_GLY1,
        S_CELL_RD,
        S_CELL_WT,
        S_CELL_WR,
        S_SCR_RD,
        S_SCR_WT,
        S_SCR_WR,
        S_FILL,
        S_RD_WT,
        S_RD_DONE,
        S_OUT
    } t_state;

endpackage

// ----- rtl/ttfw_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
module ttfw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ----- rtl/text_terminal_framebuffer_writer_unit.sv -----
// Top level of the text terminal framebuffer writer.
// Depends on ttfw_pkg and ttfw_ram (frame store and glyph store).
//
// Usage: requests enter on the i_valid/o_ready channel, one at a time; each
// produces exactly one result on o_valid/i_ready. Configuration registers
// are written on i_cfg_we with i_cfg_index and i_cfg_data while the block
// is idle.
// Every request runs through the sequencer on the single frame memory
// port: a glyph load, and a vsync without blink, go straight to the
// result; a frame read waits for the registered read data; a cursor erase
// or invert reads, modifies and writes each of the eight lines of the cell;
// a printable character first reads its two glyph words and then does the
// same; moving down past the scroll bottom copies the scroll area up a row
// byte by byte (320 bytes per row) and fills the bottom row; clear line
// fills one row of 320 bytes, and clear screen and the reset command fill
// all 9600 bytes.
// After reset the frame store is cleared to zeros, one byte a cycle over all
// 9600 bytes; no request is accepted meanwhile, but config writes still work.
// The result waits in an output register until taken; the next request is
// accepted at the earliest in the cycle after it has been taken.
module text_terminal_framebuffer_writer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_kind,
    input  logic [7:0]  i_char_code,
    input  logic [6:0]  i_new_col,
    input  logic [4:0]  i_new_row,
    input  logic [13:0] i_read_addr,
    input  logic [8:0]  i_glyph_word_index,
    input  logic [15:0] i_glyph_word,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_frame_byte,
    output logic [6:0]  o_cursor_col_now,
    output logic [4:0]  o_cursor_row_now
);
    import ttfw_pkg::*;

    // Control state.
    t_state  r_state, n_state;
    t_cellop r_op, n_op;
    t_after  r_after, n_after;
    logic [6:0]  r_col, n_col;
    logic [4:0]  r_row, n_row;
    logic [4:0]  r_blink, n_blink;
    logic [4:0]  r_first, r_last;
    logic [7:0]  r_fore, r_back;
    logic [FA_W-1:0] r_addr, n_addr;   // walking frame address
    logic [FA_W-1:0] r_end, n_end;     // exclusive end of a walk
    logic [2:0]  r_line, n_line;
    logic        r_busy_clr, n_busy_clr;
    logic        r_ovalid, n_ovalid;
    logic [7:0]  r_obyte, n_obyte;
    logic [7:0]  r_data, n_data;
    logic [15:0] r_w0, n_w0;
    logic [15:0] r_w1, n_w1;
    logic        r_gval, n_gval;
    logic [6:0]  r_ncol, n_ncol;
    logic [4:0]  r_nrow, n_nrow;
    logic [7:0]  r_code, n_code;        // character being drawn
    logic        n_fwd;                 // reset command reloads the registers

    // Frame memory port.
    logic            fm_we;
    logic [FA_W-1:0] fm_addr;
    logic [7:0]      fm_wdata, fm_rdata;
    // Glyph memory port.
    logic            gm_we;
    logic [GA_W-1:0] gm_addr;
    logic [15:0]     gm_rdata;

    ttfw_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_frame (
        .i_clk(i_clk), .i_we(fm_we), .i_addr(fm_addr),
        .i_wdata(fm_wdata), .o_rdata(fm_rdata)
    );

    ttfw_ram #(.WIDTH(16), .DEPTH(GLYPH_WORDS)) u_glyph (
        .i_clk(i_clk), .i_we(gm_we), .i_addr(gm_addr),
        .i_wdata(i_glyph_word), .o_rdata(gm_rdata)
    );

    logic [4:0] last_eff;
    assign last_eff = (r_last > 5'(TEXT_ROWS - 1)) ? 5'(TEXT_ROWS - 1) : r_last;

    // Row base: row * 320, built from shifts (256 + 64).
    function automatic logic [FA_W-1:0] row_base(input logic [4:0] row);
        return FA_W'({row, 8'd0}) + FA_W'({row, 6'd0});
    endfunction

    logic [FA_W-1:0] cell_base;
    assign cell_base = row_base(r_row) + FA_W'(r_col[6:1]);

    // Glyph line nibble for the current line, blended with colors.
    logic [15:0] gw_sel, bc16, fc16, blend;
    logic [3:0]  nib;
    always_comb begin
        gw_sel = r_line[2] ? r_w1 : r_w0;
        if (!r_gval) begin
            gw_sel = '0;
        end
        bc16  = {r_back, r_back};
        fc16  = {r_fore, r_fore};
        blend = (~gw_sel & bc16) | (gw_sel & fc16);
        case (r_line[1:0])
            2'd0:    nib = blend[15:12];
            2'd1:    nib = blend[11:8];
            2'd2:    nib = blend[7:4];
            default: nib = blend[3:0];
        endcase
    end

    logic [7:0] cell_new;
    always_comb begin
        case (r_op)
            CO_ERASE:  cell_new = r_data & ((r_col[0] ? 8'hF0 : 8'h0F) | r_back);
            CO_INVERT: cell_new = r_data ^ (r_col[0] ? 8'h0F : 8'hF0);
            default:   cell_new = r_col[0] ? {r_data[7:4], nib} : {nib, r_data[3:0]};
        endcase
    end

    assign o_ready = (r_state == S_IDLE) && !r_busy_clr && !r_ovalid;
    assign o_valid = r_ovalid;
    assign o_frame_byte = r_obyte;
    assign o_cursor_col_now = r_col;
    assign o_cursor_row_now = r_row;

    logic accept;
    assign accept = i_valid && o_ready;

    always_comb begin
        n_state = r_state; n_op = r_op; n_after = r_after;
        n_col = r_col; n_row = r_row; n_blink = r_blink;
        n_addr = r_addr; n_end = r_end; n_line = r_line;
        n_busy_clr = r_busy_clr; n_ovalid = r_ovalid; n_obyte = r_obyte;
        n_data = r_data; n_w0 = r_w0; n_w1 = r_w1; n_gval = r_gval;
        n_ncol = r_ncol; n_nrow = r_nrow; n_code = r_code; n_fwd = 1'b0;
        fm_we = 1'b0; fm_addr = r_addr; fm_wdata = r_back;
        gm_we = 1'b0; gm_addr = {i_char_code, 1'b0};

        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        if (r_busy_clr) begin
            // Power-up clearing pass: zeros.
            fm_we = 1'b1; fm_wdata = '0;
            n_addr = r_addr + 1'b1;
            if (r_addr == FA_W'(FRAME_BYTES - 1)) begin
                n_busy_clr = 1'b0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        n_obyte = '0;
                        n_line = '0;
                        case (t_kind'(i_kind))
                            K_CHAR: begin
                                n_op = CO_ERASE;
                                if (i_char_code == CH_LF) begin
                                    n_after = AF_LF; n_state = S_CELL_RD;
                                end else if (i_char_code == CH_CR) begin
                                    n_after = AF_DOWN; n_state = S_CELL_RD;
                                end else begin
                                    n_op = CO_DRAW; n_after = AF_ADV;
                                    n_gval = (i_char_code < 9'(GLYPH_COUNT));
                                    n_code = i_char_code;
                                    gm_addr = GA_W'({i_char_code, 1'b0});
                                    n_state = S_GLY0;
                                end
                            end
                            K_SETCUR: begin
                                n_op = CO_ERASE; n_after = AF_SETCUR;
                                n_ncol = (i_new_col > 7'(TEXT_COLUMNS - 1))
                                    ? 7'(TEXT_COLUMNS - 1) : i_new_col;
                                n_nrow = (i_new_row > 5'(TEXT_ROWS - 1))
                                    ? 5'(TEXT_ROWS - 1) : i_new_row;
                                n_state = S_CELL_RD;
                            end
                            K_VSYNC: begin
                                if (r_blink == 5'(BLINK_PERIOD - 1)) begin
                                    n_blink = '0; n_op = CO_INVERT;
                                    n_after = AF_NONE; n_state = S_CELL_RD;
                                end else begin
                                    n_blink = r_blink + 1'b1; n_state = S_OUT;
                                end
                            end
                            K_CLS: begin
                                n_addr = '0; n_end = FA_W'(FRAME_BYTES);
                                n_state = S_FILL;
                            end
                            K_CLL: begin
                                n_addr = row_base(r_row);
                                n_end = row_base(r_row) + FA_W'(ROW_BYTES);
                                n_state = S_FILL;
                            end
                            K_RESET: begin
                                n_col = '0; n_row = '0; n_fwd = 1'b1;
                                n_addr = '0; n_end = FA_W'(FRAME_BYTES);
                                n_state = S_FILL;
                            end
                            K_READ: begin
                                // The address is held so the read stays stable.
                                fm_addr = FA_W'(i_read_addr);
                                n_addr = FA_W'(i_read_addr);
                                n_gval = (i_read_addr < 14'(FRAME_BYTES));
                                n_state = S_RD_WT;
                            end
                            default: begin
                                gm_we = (i_glyph_word_index < 10'(GLYPH_WORDS));
                                gm_addr = GA_W'(i_glyph_word_index);
                                n_state = S_OUT;
                            end
                        endcase
                    end
                end
                S_GLY0: begin
                    // First word arrives while the second is addressed.
                    n_w0 = gm_rdata;
                    gm_addr = GA_W'({r_code, 1'b1});
                    n_state = S_GLY1;
                end
                S_GLY1: begin
                    n_w1 = gm_rdata;
                    n_state = S_CELL_RD;
                end
                S_CELL_RD: begin
                    fm_addr = cell_base + FA_W'(r_line) * FA_W'(LINE_BYTES);
                    n_addr = fm_addr;
                    n_state = S_CELL_WT;
                end
                S_CELL_WT: begin
                    n_data = fm_rdata;
                    n_state = S_CELL_WR;
                end
                S_CELL_WR: begin
                    fm_we = 1'b1; fm_wdata = cell_new;
                    n_line = r_line + 1'b1;
                    if (r_line != 3'd7) begin
                        n_state = S_CELL_RD;
                    end else begin
                        n_state = S_OUT;
                        case (r_after)
                            AF_LF:     n_col = '0;
                            AF_SETCUR: begin n_col = r_ncol; n_row = r_nrow; end
                            AF_ADV: begin
                                if (r_col == 7'(TEXT_COLUMNS - 1)) begin
                                    n_col = '0; n_after = AF_DOWN;
                                end else begin
                                    n_col = r_col + 1'b1;
                                end
                            end
                            default: ;
                        endcase
                        if (r_after == AF_DOWN ||
                            (r_after == AF_ADV && r_col == 7'(TEXT_COLUMNS - 1))) begin
                            if (r_row < last_eff) begin
                                n_row = r_row + 1'b1;
                            end else begin
                                n_addr = row_base(r_first);
                                n_end = row_base(last_eff);
                                n_state = (r_first < last_eff) ? S_SCR_RD : S_FILL;
                                if (!(r_first < last_eff)) begin
                                    n_addr = row_base(last_eff);
                                end
                                n_end = (r_first < last_eff) ? row_base(last_eff)
                                    : row_base(last_eff) + FA_W'(ROW_BYTES);
                            end
                        end
                    end
                end
                S_SCR_RD: begin
                    fm_addr = r_addr + FA_W'(ROW_BYTES);
                    n_state = S_SCR_WT;
                end
                S_SCR_WT: begin
                    n_data = fm_rdata;
                    n_state = S_SCR_WR;
                end
                S_SCR_WR: begin
                    fm_we = 1'b1; fm_wdata = r_data;
                    n_addr = r_addr + 1'b1;
                    if (n_addr == r_end) begin
                        n_end = r_end + FA_W'(ROW_BYTES);
                        n_state = S_FILL;
                    end else begin
                        n_state = S_SCR_RD;
                    end
                end
                S_FILL: begin
                    fm_we = 1'b1;
                    n_addr = r_addr + 1'b1;
                    if (n_addr == r_end) begin
                        n_state = S_OUT;
                    end
                end
                S_RD_WT: begin
                    n_state = S_RD_DONE;
                end
                S_RD_DONE: begin
                    n_obyte = r_gval ? fm_rdata : 8'd0;
                    n_state = S_OUT;
                end
                S_OUT: begin
                    n_ovalid = 1'b1;
                    n_state = S_IDLE;
                end
                default: n_state = S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_col <= '0; r_row <= '0; r_blink <= '0;
            r_addr <= '0; r_busy_clr <= 1'b1; r_ovalid <= 1'b0;
            r_line <= '0;
        end else begin
            r_state <= n_state;
            r_col <= n_col; r_row <= n_row; r_blink <= n_blink;
            r_addr <= n_addr; r_busy_clr <= n_busy_clr; r_ovalid <= n_ovalid;
            r_line <= n_line;
        end
    end

    // Configuration registers; the reset command restores them at acceptance.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || n_fwd) begin
            r_first <= '0;
            r_last  <= 5'(TEXT_ROWS - 1);
            r_fore  <= 8'hFF;
            r_back  <= 8'h00;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FIRST: r_first <= i_cfg_data[4:0];
                REG_LAST:  r_last  <= i_cfg_data[4:0];
                REG_FORE:  r_fore  <= i_cfg_data;
                REG_BACK:  r_back  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op; r_after <= n_after; r_end <= n_end;
        r_obyte <= n_obyte; r_data <= n_data; r_w0 <= n_w0; r_w1 <= n_w1;
        r_gval <= n_gval; r_ncol <= n_ncol; r_nrow <= n_nrow;
        r_code <= n_code;
    end

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col < 7'(TEXT_COLUMNS)) else $error("cursor column out of range");
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row < 5'(TEXT_ROWS)) else $error("cursor row out of range");
    a_no_accept_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy_clr |-> !o_ready) else $error("request taken during clear pass");
    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state) == S_OUT) else $error("stray result");
    a_blink_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_blink < 5'(BLINK_PERIOD)) else $error("blink count out of range");
endmodule

// ----- verif/text_terminal_framebuffer_writer_unit_tb.sv -----
// Self-checking testbench for the text terminal framebuffer writer.
// Depends on ttfw_pkg and the text_terminal_framebuffer_writer_unit RTL.
`timescale 1ns / 100ps

module text_terminal_framebuffer_writer_unit_tb;
    import ttfw_pkg::*;

    localparam int WATCHDOG_CYCLES = 200000;
    localparam int RANDOM_PHASES   = 7;
    localparam int PHASE_REQUESTS  = 150;
    localparam int DIRECTED_ROWS   = 23;

    // One request as it appears on the input channel.
    typedef struct {
        t_kind       kind;
        logic [7:0]  code;
        logic [6:0]  col;
        logic [4:0]  row;
        logic [13:0] addr;
        logic [8:0]  gidx;
        logic [15:0] gword;
    } t_request;

    // One result as it appears on the output channel.
    typedef struct {
        logic [7:0] fbyte;
        logic [6:0] col;
        logic [4:0] row;
    } t_screen_result;

    // A row of the directed table; the typed result is used when has_result is set.
    typedef struct {
        t_request       req;
        bit             has_result;
        t_screen_result res;
    } t_directed_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [2:0]  i_kind = '0;
    logic [7:0]  i_char_code = '0;
    logic [6:0]  i_new_col = '0;
    logic [4:0]  i_new_row = '0;
    logic [13:0] i_read_addr = '0;
    logic [8:0]  i_glyph_word_index = '0;
    logic [15:0] i_glyph_word = '0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [7:0]  i_cfg_data = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [7:0]  o_frame_byte;
    logic [6:0]  o_cursor_col_now;
    logic [4:0]  o_cursor_row_now;

    text_terminal_framebuffer_writer_unit u_top (.*);

    always #6 i_clk = ~i_clk;

    // Shadow copy of the block's state, updated once per accepted request.
    logic [7:0]  shadow_frame [FRAME_BYTES];
    logic [15:0] shadow_glyph [GLYPH_WORDS];
    bit          glyph_loaded [GLYPH_WORDS];
    logic [7:0]  drawable_codes [$];
    int          cur_col, cur_row, blink_ticks;
    int          scr_first, scr_last, fore_byte, back_byte;

    t_screen_result pending_results [$];
    int  error_count = 0;
    int  stall_cycles = 0;
    bit  calm_sender = 1'b0;
    bit  calm_receiver = 1'b0;
    int  receiver_hold = 0;

    t_directed_row directed [DIRECTED_ROWS];

    function automatic int idle_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 45) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int cell_base();
        return cur_row * ROW_BYTES + (cur_col >> 1);
    endfunction

    // The cursor nibble is masked with the background color; the other column is kept.
    function automatic void erase_cell();
        int p;
        logic [7:0] keep;
        p = cell_base();
        keep = ((cur_col & 1) ? 8'hF0 : 8'h0F) | back_byte[7:0];
        for (int i = 0; i < 8; i++) shadow_frame[p + i * LINE_BYTES] &= keep;
    endfunction

    function automatic void invert_cell();
        int p;
        logic [7:0] flip;
        p = cell_base();
        flip = (cur_col & 1) ? 8'h0F : 8'hF0;
        for (int i = 0; i < 8; i++) shadow_frame[p + i * LINE_BYTES] ^= flip;
    endfunction

    function automatic void fill_back(int first, int last);
        for (int i = first; i < last && i < FRAME_BYTES; i++) shadow_frame[i] = back_byte[7:0];
    endfunction

    function automatic int bottom_row();
        return (scr_last > TEXT_ROWS - 1) ? TEXT_ROWS - 1 : scr_last;
    endfunction

    // Moving down at or below the bottom of the scroll area shifts that area up a row.
    function automatic void line_down();
        int last;
        last = bottom_row();
        if (cur_row < last) begin
            cur_row++;
        end else begin
            for (int i = scr_first * ROW_BYTES; i < last * ROW_BYTES; i++)
                shadow_frame[i] = shadow_frame[i + ROW_BYTES];
            fill_back(last * ROW_BYTES, (last + 1) * ROW_BYTES);
        end
    endfunction

    function automatic void draw_char(logic [7:0] code);
        logic [15:0] w0, w1, bc, fc;
        logic [3:0]  nib;
        bit          even;
        int          p;
        even = (cur_col & 1) == 0;
        w0 = shadow_glyph[{code, 1'b0}];
        w1 = shadow_glyph[{code, 1'b1}];
        bc = {back_byte[7:0], back_byte[7:0]};
        fc = {fore_byte[7:0], fore_byte[7:0]};
        w0 = (~w0 & bc) | (w0 & fc);
        w1 = (~w1 & bc) | (w1 & fc);
        p = cell_base();
        for (int i = 0; i < 8; i++) begin
            nib = (i < 4) ? w0[15 - 4 * i -: 4] : w1[15 - 4 * (i - 4) -: 4];
            if (even) shadow_frame[p] = {nib, shadow_frame[p][3:0]};
            else shadow_frame[p] = {shadow_frame[p][7:4], nib};
            p += LINE_BYTES;
        end
    endfunction

    function automatic void default_regs();
        scr_first = 0;
        scr_last  = TEXT_ROWS - 1;
        fore_byte = 255;
        back_byte = 0;
    endfunction

    // Applies one request to the shadow state and returns the result it causes.
    function automatic t_screen_result apply_request(t_request r);
        t_screen_result res;
        res.fbyte = '0;
        case (r.kind)
            K_CHAR: begin
                if (r.code == CH_LF) begin
                    erase_cell();
                    cur_col = 0;
                end else if (r.code == CH_CR) begin
                    erase_cell();
                    line_down();
                end else begin
                    draw_char(r.code);
                    cur_col++;
                    if (cur_col >= TEXT_COLUMNS) begin
                        cur_col = 0;
                        line_down();
                    end
                end
            end
            K_SETCUR: begin
                erase_cell();
                cur_col = (r.col > TEXT_COLUMNS - 1) ? TEXT_COLUMNS - 1 : r.col;
                cur_row = (r.row > TEXT_ROWS - 1) ? TEXT_ROWS - 1 : r.row;
            end
            K_VSYNC: begin
                blink_ticks++;
                if (blink_ticks >= BLINK_PERIOD) begin
                    blink_ticks = 0;
                    invert_cell();
                end
            end
            K_CLS: fill_back(0, FRAME_BYTES);
            K_CLL: fill_back(cur_row * ROW_BYTES, (cur_row + 1) * ROW_BYTES);
            K_RESET: begin
                cur_col = 0;
                cur_row = 0;
                default_regs();
                fill_back(0, FRAME_BYTES);
            end
            K_READ: if (r.addr < FRAME_BYTES) res.fbyte = shadow_frame[r.addr];
            default: begin
                shadow_glyph[r.gidx] = r.gword;
                glyph_loaded[r.gidx] = 1'b1;
                if (glyph_loaded[r.gidx ^ 9'd1]) begin
                    bit known;
                    known = 1'b0;
                    foreach (drawable_codes[i]) if (drawable_codes[i] == r.gidx[8:1]) known = 1'b1;
                    if (!known) drawable_codes.push_back(r.gidx[8:1]);
                end
            end
        endcase
        res.col = cur_col[6:0];
        res.row = cur_row[4:0];
        return res;
    endfunction

    // Random request; characters only use glyphs that have been fully loaded.
    function automatic t_request random_request();
        t_request r;
        int pick;
        r.code  = 8'($urandom_range(0, 255));
        r.col   = 7'($urandom_range(0, 127));
        r.row   = 5'($urandom_range(0, 31));
        r.addr  = ($urandom_range(0, 9) < 8) ? 14'($urandom_range(0, FRAME_BYTES - 1))
                                             : 14'($urandom_range(0, 16383));
        r.gidx  = 9'($urandom_range(0, GLYPH_WORDS - 1));
        r.gword = 16'($urandom_range(0, 65535));
        pick = $urandom_range(0, 99);
        if (pick < 35) r.kind = K_CHAR;
        else if (pick < 43) r.kind = K_SETCUR;
        else if (pick < 58) r.kind = K_VSYNC;
        else if (pick < 59) r.kind = K_CLS;
        else if (pick < 62) r.kind = K_CLL;
        else if (pick < 63) r.kind = K_RESET;
        else if (pick < 88) r.kind = K_READ;
        else r.kind = K_GLYPH;
        if (r.kind == K_CHAR) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) r.code = CH_LF;
            else if (pick == 1) r.code = CH_CR;
            else if (!(glyph_loaded[{r.code, 1'b0}] && glyph_loaded[{r.code, 1'b1}]))
                r.code = drawable_codes[$urandom_range(0, drawable_codes.size() - 1)];
        end
        // Half of the glyph loads try to complete a half-loaded character.
        if (r.kind == K_GLYPH && $urandom_range(0, 1) == 1) begin
            for (int i = 0; i < 16; i++) begin
                if (glyph_loaded[r.gidx] && !glyph_loaded[r.gidx ^ 9'd1]) break;
                r.gidx = 9'($urandom_range(0, GLYPH_WORDS - 1));
            end
            if (glyph_loaded[r.gidx]) r.gidx = r.gidx ^ 9'd1;
        end
        return r;
    endfunction

    // Presents a request, starting at the current edge, and waits until it is accepted.
    task automatic send_request(t_request r, bit has_result, t_screen_result typed);
        t_screen_result predicted;
        i_valid            <= 1'b1;
        i_kind             <= r.kind;
        i_char_code        <= r.code;
        i_new_col          <= r.col;
        i_new_row          <= r.row;
        i_read_addr        <= r.addr;
        i_glyph_word_index <= r.gidx;
        i_glyph_word       <= r.gword;
        do @(posedge i_clk); while (!o_ready);
        predicted = apply_request(r);
        pending_results.push_back(has_result ? typed : predicted);
    endtask

    // Gap after an accepted request; valid drops only when a gap follows.
    task automatic sender_gap();
        int gap;
        gap = idle_gap(calm_sender);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Writes all four registers, one per edge, while no request is in flight.
    task automatic write_config(int first, int last, int fore, int back);
        int vals [4];
        vals = '{first, last, fore, back};
        for (int i = 0; i < 4; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= i[1:0];
            i_cfg_data  <= vals[i][7:0];
            @(posedge i_clk);
        end
        i_cfg_we  <= 1'b0;
        scr_first = first & 5'h1F;
        scr_last  = last & 5'h1F;
        fore_byte = fore & 8'hFF;
        back_byte = back & 8'hFF;
    endtask

    // Receiver side: random ready gaps and comparison against the oldest expectation.
    always @(posedge i_clk) begin
        t_screen_result want;
        if (o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result byte %h col %0d row %0d",
                         $realtime, o_frame_byte, o_cursor_col_now, o_cursor_row_now);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_frame_byte !== want.fbyte) begin
                    $display("%0t: frame_byte expected %h actual %h",
                             $realtime, want.fbyte, o_frame_byte);
                    error_count++;
                end
                if (o_cursor_col_now !== want.col) begin
                    $display("%0t: cursor_col expected %0d actual %0d",
                             $realtime, want.col, o_cursor_col_now);
                    error_count++;
                end
                if (o_cursor_row_now !== want.row) begin
                    $display("%0t: cursor_row expected %0d actual %0d",
                             $realtime, want.row, o_cursor_row_now);
                    error_count++;
                end
            end
            receiver_hold = idle_gap(calm_receiver);
        end else if (receiver_hold > 0) begin
            receiver_hold--;
        end
        i_ready <= i_rst_n && (receiver_hold == 0);
    end

    // Watchdog on cycles in which neither channel moves a request or result.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic t_request mk(t_kind k, int code, int col, int row,
                                    int addr, int gidx, int gword);
        t_request r;
        r = '{k, code[7:0], col[6:0], row[4:0], addr[13:0], gidx[8:0], gword[15:0]};
        return r;
    endfunction

    function automatic t_screen_result rs(int b, int c, int r);
        t_screen_result x;
        x = '{b[7:0], c[6:0], r[4:0]};
        return x;
    endfunction

    initial begin
        int settings [RANDOM_PHASES][4];
        t_screen_result none;
        none = rs(0, 0, 0);
        foreach (shadow_frame[i]) shadow_frame[i] = '0;
        foreach (glyph_loaded[i]) glyph_loaded[i] = 1'b0;
        cur_col = 0;
        cur_row = 0;
        blink_ticks = 0;
        default_regs();

        // The frame is all zero after reset, so the first reads are known.
        directed = '{
            '{mk(K_READ, 0, 0, 0, 0, 0, 0), 1, rs(0, 0, 0)},
            '{mk(K_READ, 255, 127, 31, FRAME_BYTES - 1, 511, 65535), 1, rs(0, 0, 0)},
            '{mk(K_READ, 0, 0, 0, 16383, 0, 0), 1, rs(0, 0, 0)},
            '{mk(K_GLYPH, 0, 0, 0, 0, 0, 16'hFFFF), 1, rs(0, 0, 0)},
            '{mk(K_GLYPH, 0, 0, 0, 0, 1, 16'h0000), 1, rs(0, 0, 0)},
            '{mk(K_GLYPH, 0, 0, 0, 0, 510, 16'hA5C3), 1, rs(0, 0, 0)},
            '{mk(K_GLYPH, 0, 0, 0, 0, 511, 16'h5A3C), 1, rs(0, 0, 0)},
            '{mk(K_GLYPH, 0, 0, 0, 0, 9'h082, 16'h1234), 1, rs(0, 0, 0)},
            '{mk(K_GLYPH, 0, 0, 0, 0, 9'h083, 16'h8001), 1, rs(0, 0, 0)},
            '{mk(K_CHAR, 8'h00, 0, 0, 0, 0, 0), 1, rs(0, 1, 0)},
            '{mk(K_CHAR, 8'hFF, 0, 0, 0, 0, 0), 1, rs(0, 2, 0)},
            '{mk(K_READ, 0, 0, 0, 0, 0, 0), 1, rs(8'hFA, 2, 0)},
            '{mk(K_CHAR, 8'h41, 0, 0, 0, 0, 0), 1, rs(0, 3, 0)},
            '{mk(K_SETCUR, 0, 127, 31, 0, 0, 0), 1, rs(0, 79, 29)},
            '{mk(K_CHAR, 8'h41, 0, 0, 0, 0, 0), 1, rs(0, 0, 29)},
            '{mk(K_CHAR, CH_LF, 0, 0, 0, 0, 0), 1, rs(0, 0, 29)},
            '{mk(K_CHAR, CH_CR, 0, 0, 0, 0, 0), 1, rs(0, 0, 29)},
            '{mk(K_READ, 0, 0, 0, 28 * ROW_BYTES + 39, 0, 0), 0, none},
            '{mk(K_SETCUR, 0, 1, 0, 0, 0, 0), 1, rs(0, 1, 0)},
            '{mk(K_VSYNC, 0, 0, 0, 0, 0, 0), 0, none},
            '{mk(K_CLL, 0, 0, 0, 0, 0, 0), 1, rs(0, 1, 0)},
            '{mk(K_CLS, 0, 0, 0, 0, 0, 0), 1, rs(0, 1, 0)},
            '{mk(K_RESET, 0, 0, 0, 0, 0, 0), 1, rs(0, 0, 0)}
        };

        // Scroll areas: full screen, single rows at both ends, an inverted pair,
        // two with a bottom row beyond the screen, and a random one.
        settings = '{
            '{0, 29, 255, 0}, '{0, 0, 0, 255}, '{29, 29, 8'h5A, 8'hA5},
            '{20, 5, 8'h3C, 8'hC3}, '{31, 31, 8'h81, 8'h7E},
            '{27, 31, 0, 0}, '{0, 0, 0, 0}
        };
        settings[6][0] = $urandom_range(0, 26);
        settings[6][1] = settings[6][0] + $urandom_range(0, 3);
        settings[6][2] = $urandom_range(0, 255);
        settings[6][3] = $urandom_range(0, 255);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_config(0, 29, 255, 0);

        foreach (directed[i]) begin
            send_request(directed[i].req, directed[i].has_result, directed[i].res);
            sender_gap();
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain_results();
            write_config(settings[ph][0], settings[ph][1], settings[ph][2], settings[ph][3]);
            calm_sender   = ph[0];
            calm_receiver = (ph % 3) == 1;
            for (int n = 0; n < PHASE_REQUESTS; n++) begin
                send_request(random_request(), 1'b0, none);
                // Now and then the sender waits for every outstanding result.
                if ($urandom_range(0, 49) == 0) drain_results();
                sender_gap();
            end
        end

        drain_results();
        repeat (40) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
